@@ rtl/e2bmw_pkg.sv @@
// Shared constants and types of the ext2 block map walker.
package e2bmw_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned FUNC_W        = 2;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned SLOT_W        = 4;
  localparam int unsigned BSL_W         = 3;
  localparam int unsigned LVL_W         = 2;

  localparam int unsigned POINTER_SLOTS = 15;
  localparam int unsigned DIRECT_SLOTS  = 12;
  localparam int unsigned SINGLE_SLOT   = POINTER_SLOTS - 3;
  localparam int unsigned DOUBLE_SLOT   = POINTER_SLOTS - 2;
  localparam int unsigned TRIPLE_SLOT   = POINTER_SLOTS - 1;

  // log2 of the smallest block size, and of pointers per smallest block
  localparam int unsigned BLK_SHIFT_MIN = 10;
  localparam int unsigned PTR_SHIFT_MIN = 8;

  // walk depth still to go
  localparam logic [LVL_W-1:0] LVL_NONE   = 2'd0;
  localparam logic [LVL_W-1:0] LVL_SINGLE = 2'd1;
  localparam logic [LVL_W-1:0] LVL_DOUBLE = 2'd2;
  localparam logic [LVL_W-1:0] LVL_TRIPLE = 2'd3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_XLATE = 2'd1,
    FUNC_RESP  = 2'd2
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_PTR  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_HIT  = 2'd2
  } kind_e;

endpackage

@@ rtl/e2bmw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module e2bmw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ext2_block_map_walker.sv @@
// Top level of the ext2 block map walker: decode, pointer RAM, address stage, output queue.
//
// The walker turns a file's logical block number into the byte address of its
// data block. Load items write the inode's 15 pointer slots into a small RAM and
// empty the one-entry cache of the last translated block number. A translate
// item either hits that cache (kind 2, address 0) or starts a walk: a direct
// block gives the data block address at once, an indirect one gives the address
// of a 4-byte pointer word to fetch. Each fetched word comes back as a response
// item and yields the next pointer address or, at the last level, the data
// block address. Block size is 1024 << block_size_log; addresses wrap modulo
// 2^32. The block takes one item per cycle while input stall is low. Every item
// is decoded in the cycle it is accepted, with the walk state updated there, and
// the pointer RAM is read at that edge; its registered read data feeds the address
// stage in the next cycle, and the result enters a three-entry output queue, from
// which it is offered on the output and taken while output stall is low. Input
// stall rises only while the queue and the address stage together hold at least
// three results. The pointer slots are undefined until loaded, so no clearing
// pass follows reset.
// block_size_log must only be written while no item is in flight.
module ext2_block_map_walker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [e2bmw_pkg::BSL_W-1:0]        cfg_wdata_i,
  // input items
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [e2bmw_pkg::FUNC_W-1:0]       func_i,
  input  logic [e2bmw_pkg::SLOT_W-1:0]       slot_i,
  input  logic [e2bmw_pkg::WORD_W-1:0]       word_i,
  input  logic [e2bmw_pkg::WORD_W-1:0]       block_number_i,
  // result items
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [e2bmw_pkg::KIND_W-1:0]       kind_o,
  output logic [e2bmw_pkg::WORD_W-1:0]       address_o
);

  import e2bmw_pkg::*;

  localparam int unsigned Q_DEPTH = 3;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);
  localparam int unsigned SH_W    = 5;

  // configuration register
  logic [BSL_W-1:0]  bsl_q;

  // walk and cache state
  logic              cache_valid_q, cache_valid_d;
  logic [WORD_W-1:0] cached_q, cached_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic [WORD_W-1:0] rem_q, rem_d;

  // address stage
  logic              s1_valid_q, s1_valid_d;
  kind_e             s1_kind_q, s1_kind_d;
  logic              s1_use_ram_q, s1_use_ram_d;
  logic [WORD_W-1:0] s1_word_q, s1_word_d;
  logic [WORD_W-1:0] s1_off_q, s1_off_d;
  logic [WORD_W-1:0] s1_base;
  logic [WORD_W-1:0] s1_addr;

  // pointer RAM
  logic              ram_we;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // output queue
  kind_e             q_kind_q [Q_DEPTH];
  logic [WORD_W-1:0] q_addr_q [Q_DEPTH];
  logic [Q_AW-1:0]   q_wptr_q, q_rptr_q;
  logic [Q_CW-1:0]   q_cnt_q, q_cnt_d;
  logic              q_push, q_pop;

  // decode helpers
  logic              in_acc;
  logic [SH_W-1:0]   psh;
  logic [SH_W-1:0]   psh2;
  logic [SH_W-1:0]   blk_sh;
  logic [WORD_W-1:0] pc1, pc2;
  logic [WORD_W-1:0] lim1, lim2;
  logic [WORD_W-1:0] m1, m2, m3;
  logic              hit;

  // ---------------------------------------------------------------------------
  // Handshake: accept while fewer than three results are held or in flight.
  // ---------------------------------------------------------------------------
  assign in_stall_o = ({1'b0, q_cnt_q} + (Q_CW + 1)'(s1_valid_q)) >= (Q_CW + 1)'(Q_DEPTH);
  assign in_acc     = in_valid_i & ~in_stall_o;

  // Level geometry from the block size: pointers per block is 1 << psh.
  assign psh    = SH_W'(bsl_q) + SH_W'(PTR_SHIFT_MIN);
  assign psh2   = {psh[SH_W-2:0], 1'b0};
  assign blk_sh = SH_W'(bsl_q) + SH_W'(BLK_SHIFT_MIN);
  assign pc1    = WORD_W'(1) << psh;
  assign pc2    = WORD_W'(1) << psh2;
  assign lim1   = WORD_W'(DIRECT_SLOTS) + pc1;
  assign lim2   = lim1 + pc2;

  // Index within the single, double and triple trees, worked out side by side.
  assign m1  = block_number_i - WORD_W'(DIRECT_SLOTS);
  assign m2  = block_number_i - lim1;
  assign m3  = block_number_i - lim2;
  assign hit = cache_valid_q && (block_number_i == cached_q);

  // ---------------------------------------------------------------------------
  // Decode: update walk and cache state, issue the RAM read, load the
  // address stage.
  // ---------------------------------------------------------------------------
  always_comb begin
    cache_valid_d = cache_valid_q;
    cached_d      = cached_q;
    lvl_d         = lvl_q;
    rem_d         = rem_q;
    s1_valid_d    = 1'b0;
    s1_kind_d     = KIND_PTR;
    s1_use_ram_d  = 1'b0;
    s1_word_d     = word_i;
    s1_off_d      = '0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = SLOT_W'(SINGLE_SLOT);
    if (in_acc) begin
      unique case (func_e'(func_i))
        FUNC_LOAD: begin
          // an out-of-range slot is dropped, the cache is emptied regardless
          ram_we        = (slot_i < SLOT_W'(POINTER_SLOTS));
          cache_valid_d = 1'b0;
        end
        FUNC_XLATE: begin
          s1_valid_d = 1'b1;
          if (hit) begin
            // no read, address zero, walk left as it is
            s1_kind_d = KIND_HIT;
            s1_word_d = '0;
          end else begin
            cached_d      = block_number_i;
            cache_valid_d = 1'b1;
            s1_use_ram_d  = 1'b1;
            ram_re        = 1'b1;
            if (block_number_i < WORD_W'(DIRECT_SLOTS)) begin
              lvl_d     = LVL_NONE;
              s1_kind_d = KIND_DATA;
              ram_raddr = block_number_i[SLOT_W-1:0];
            end else if (block_number_i < lim1) begin
              lvl_d     = LVL_SINGLE;
              rem_d     = '0;
              ram_raddr = SLOT_W'(SINGLE_SLOT);
              s1_off_d  = m1 << 2;
            end else if (block_number_i < lim2) begin
              lvl_d     = LVL_DOUBLE;
              rem_d     = m2 & (pc1 - WORD_W'(1));
              ram_raddr = SLOT_W'(DOUBLE_SLOT);
              s1_off_d  = (m2 >> psh) << 2;
            end else begin
              lvl_d     = LVL_TRIPLE;
              rem_d     = m3 & (pc2 - WORD_W'(1));
              ram_raddr = SLOT_W'(TRIPLE_SLOT);
              s1_off_d  = (m3 >> psh2) << 2;
            end
          end
        end
        FUNC_RESP: begin
          unique case (lvl_q)
            LVL_TRIPLE: begin
              s1_valid_d = 1'b1;
              s1_off_d   = (rem_q >> psh) << 2;
              rem_d      = rem_q & (pc1 - WORD_W'(1));
              lvl_d      = LVL_DOUBLE;
            end
            LVL_DOUBLE: begin
              s1_valid_d = 1'b1;
              s1_off_d   = rem_q << 2;
              rem_d      = '0;
              lvl_d      = LVL_SINGLE;
            end
            LVL_SINGLE: begin
              s1_valid_d = 1'b1;
              s1_kind_d  = KIND_DATA;
              lvl_d      = LVL_NONE;
            end
            default: begin
              // no walk in progress: drop the response
            end
          endcase
        end
        default: begin
          // unused function code: drop
        end
      endcase
    end
  end

  e2bmw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (POINTER_SLOTS)
  ) u_ptr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_i),
    .wdata_i (word_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsl_q         <= '0;
      cache_valid_q <= 1'b0;
      cached_q      <= '0;
      lvl_q         <= LVL_NONE;
      rem_q         <= '0;
      s1_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bsl_q <= cfg_wdata_i;
      end
      cache_valid_q <= cache_valid_d;
      cached_q      <= cached_d;
      lvl_q         <= lvl_d;
      rem_q         <= rem_d;
      s1_valid_q    <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_kind_q    <= s1_kind_d;
    s1_use_ram_q <= s1_use_ram_d;
    s1_word_q    <= s1_word_d;
    s1_off_q     <= s1_off_d;
  end

  // ---------------------------------------------------------------------------
  // Address stage: block base from the RAM word or the response word.
  // ---------------------------------------------------------------------------
  assign s1_base = s1_use_ram_q ? ram_rdata : s1_word_q;
  assign s1_addr = (s1_base << blk_sh) + s1_off_q;

  // ---------------------------------------------------------------------------
  // Output queue
  // ---------------------------------------------------------------------------
  assign q_push  = s1_valid_q;
  assign q_pop   = out_valid_o & ~out_stall_i;
  assign q_cnt_d = q_cnt_q + Q_CW'(q_push) - Q_CW'(q_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wptr_q <= '0;
      q_rptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      q_cnt_q <= q_cnt_d;
      if (q_push) begin
        q_wptr_q <= (q_wptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : q_wptr_q + Q_AW'(1);
      end
      if (q_pop) begin
        q_rptr_q <= (q_rptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : q_rptr_q + Q_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_push) begin
      q_kind_q[q_wptr_q] <= s1_kind_q;
      q_addr_q[q_wptr_q] <= s1_addr;
    end
  end

  assign out_valid_o = (q_cnt_q != '0);
  assign kind_o      = q_kind_q[q_rptr_q];
  assign address_o   = q_addr_q[q_rptr_q];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_pop) |-> (q_cnt_q < Q_CW'(Q_DEPTH)))
    else $error("output queue overflow");

  a_queue_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= Q_CW'(Q_DEPTH))
    else $error("output queue count out of range");

  a_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (s1_kind_q == KIND_HIT)) |-> (s1_addr == '0))
    else $error("cache hit with non-zero address");

  a_single_no_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lvl_q == LVL_SINGLE) |-> (rem_q == '0))
    else $error("index left over at the last indirect level");

  a_ram_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (slot_i < SLOT_W'(POINTER_SLOTS)))
    else $error("write to a pointer slot out of range");

endmodule
